[src/dfla_pkg.sv]
// ---------------------------------------------------------------------------
// dfla_pkg: shared types and constants of the free-list slot allocator
// holds status codes, field widths and the front-to-back request struct
// ---------------------------------------------------------------------------
package dfla_pkg;

    localparam int CAPACITY   = 1024;
    localparam int HEAPS      = 4;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int HEAP_W     = 2;
    localparam int TOT_W      = 32;
    localparam int MEM_AW     = HEAP_W + IDX_W;

    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ABSENT    = 3'd1,
        ST_FULL      = 3'd2,
        ST_BEYOND_HW = 3'd3,
        ST_DOUBLE    = 3'd4
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    localparam logic [1:0] REG_CAP0 = 2'd0;
    localparam logic [1:0] REG_CAP1 = 2'd1;
    localparam logic [1:0] REG_CAP2 = 2'd2;
    localparam logic [1:0] REG_CAP3 = 2'd3;

    // request as it leaves the front queue
    typedef struct packed {
        op_t               op;
        logic [HEAP_W-1:0] heap;
        logic [IDX_W-1:0]  idx;
    } req_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_OUT
    } bk_state_t;

endpackage

[src/dfla_front.sv]
// ---------------------------------------------------------------------------
// dfla_front: input stage and request queue
// two-entry fifo decouples the input channel from the back end
// ---------------------------------------------------------------------------
module dfla_front
    import dfla_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  req_t        in_req,
    output logic        q_valid,
    input  logic        q_pop,
    output req_t        q_req
);

    req_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_req    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_req;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !in_ready) else $error("push into full queue");
    a_empty_novalid: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 |-> !q_valid) else $error("valid from empty queue");
`endif

endmodule

[src/dfla_back.sv]
// ---------------------------------------------------------------------------
// dfla_back: allocator engine
// per-heap counters, free stack memory and freed-flag memory with clear sweep
// ---------------------------------------------------------------------------
module dfla_back
    import dfla_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CNT_W-1:0]  cap [HEAPS],
    input  logic              q_valid,
    output logic              q_pop,
    input  req_t              q_req,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        out_status,
    output logic [IDX_W-1:0]  out_slot,
    output logic              out_reused,
    output logic [CNT_W-1:0]  out_live,
    output logic [CNT_W-1:0]  out_stack,
    output logic [CNT_W-1:0]  out_hw,
    output logic [TOT_W-1:0]  out_atot,
    output logic [TOT_W-1:0]  out_ftot,
    output logic [TOT_W-1:0]  out_rtot
);

    localparam int DEPTH = HEAPS * CAPACITY;

    logic [IDX_W-1:0] stack_mem [DEPTH];
    logic             flag_mem  [DEPTH];

    logic [CNT_W-1:0] scnt_reg [HEAPS];
    logic [CNT_W-1:0] hmark_reg [HEAPS];
    logic [CNT_W-1:0] live_reg [HEAPS];
    logic [TOT_W-1:0] atot_reg [HEAPS];
    logic [TOT_W-1:0] ftot_reg [HEAPS];
    logic [TOT_W-1:0] rtot_reg [HEAPS];

    bk_state_t        state_reg, state_next;
    req_t             req_reg;
    logic [MEM_AW:0]  clr_reg;
    logic             clearing;

    logic [IDX_W-1:0] top_rd_reg;
    logic             flag_rd_reg;

    logic [2:0]       st_reg;
    logic [IDX_W-1:0] slot_reg;
    logic             reused_reg;

    // decode of the current request
    logic [HEAP_W-1:0] h;
    logic [CNT_W-1:0]  capc;
    logic [CNT_W-1:0]  sc;
    logic [MEM_AW-1:0] idx_addr;
    logic              absent;
    logic              take;
    logic              do_pop, do_fresh, do_push;
    logic [2:0]        st_c;
    logic [IDX_W-1:0]  slot_c;

    assign clearing = !clr_reg[MEM_AW];
    assign take     = (state_reg == BK_IDLE) && q_valid && !clearing;
    assign q_pop    = take;

    always_comb begin
        unique case (state_reg)
            BK_IDLE: state_next = take ? BK_READ : BK_IDLE;
            BK_READ: state_next = BK_OUT;
            BK_OUT:  state_next = out_ready ? BK_IDLE : BK_OUT;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        out_valid = (state_reg == BK_OUT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (clearing) begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            req_reg <= q_req;
        end
    end

    // memory addresses come from the queued request and the live stack count
    logic [HEAP_W-1:0] qh;
    logic [CNT_W-1:0]  qsc_m1;
    assign qh     = q_req.heap;
    assign qsc_m1 = scnt_reg[qh] - 1'b1;

    always_ff @(posedge aclk) begin
        if (take) begin
            top_rd_reg  <= stack_mem[{qh, qsc_m1[IDX_W-1:0]}];
            flag_rd_reg <= flag_mem[{qh, q_req.idx}];
        end
    end

    always_comb begin
        h           = req_reg.heap;
        capc        = (cap[h] > CAP_MAX) ? CAP_MAX : cap[h];
        sc          = scnt_reg[h];
        idx_addr    = {h, req_reg.idx};
        absent      = (cap[h] == '0);
        do_pop      = 1'b0;
        do_fresh    = 1'b0;
        do_push     = 1'b0;
        slot_c      = '0;
        st_c        = ST_OK;
        if (absent) begin
            st_c = ST_ABSENT;
        end else if (req_reg.op == OP_ALLOC) begin
            if (sc != '0) begin
                do_pop = 1'b1;
                slot_c = top_rd_reg;
            end else if (hmark_reg[h] >= capc) begin
                st_c = ST_FULL;
            end else begin
                do_fresh = 1'b1;
                slot_c   = hmark_reg[h][IDX_W-1:0];
            end
        end else begin
            if ({1'b0, req_reg.idx} >= hmark_reg[h]) begin
                st_c = ST_BEYOND_HW;
            end else if (flag_rd_reg) begin
                st_c = ST_DOUBLE;
            end else if (sc < CAP_MAX) begin
                do_push = 1'b1;
            end else begin
                st_c = ST_DOUBLE;
            end
        end
    end

    logic step;
    assign step = (state_reg == BK_READ);

    always_ff @(posedge aclk) begin
        if (clearing) begin
            flag_mem[clr_reg[MEM_AW-1:0]] <= 1'b0;
        end else if (step && do_pop) begin
            flag_mem[{h, top_rd_reg}] <= 1'b0;
        end else if (step && do_push) begin
            flag_mem[idx_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && do_push) begin
            stack_mem[{h, sc[IDX_W-1:0]}] <= req_reg.idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HEAPS; i++) begin
                scnt_reg[i]  <= '0;
                hmark_reg[i] <= '0;
                live_reg[i]  <= '0;
                atot_reg[i]  <= '0;
                ftot_reg[i]  <= '0;
                rtot_reg[i]  <= '0;
            end
        end else if (step) begin
            if (do_pop) begin
                scnt_reg[h] <= sc - 1'b1;
                rtot_reg[h] <= rtot_reg[h] + 1'b1;
            end
            if (do_fresh) begin
                hmark_reg[h] <= hmark_reg[h] + 1'b1;
            end
            if (do_pop || do_fresh) begin
                live_reg[h] <= live_reg[h] + 1'b1;
                atot_reg[h] <= atot_reg[h] + 1'b1;
            end
            if (do_push) begin
                scnt_reg[h] <= sc + 1'b1;
                live_reg[h] <= live_reg[h] - 1'b1;
                ftot_reg[h] <= ftot_reg[h] + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            st_reg     <= st_c;
            slot_reg   <= slot_c;
            reused_reg <= do_pop;
        end
    end

    logic hide;
    assign hide       = (st_reg == ST_ABSENT);
    assign out_status = st_reg;
    assign out_slot   = slot_reg;
    assign out_reused = reused_reg;
    assign out_live   = hide ? '0 : live_reg[h];
    assign out_stack  = hide ? '0 : scnt_reg[h];
    assign out_hw     = hide ? '0 : hmark_reg[h];
    assign out_atot   = hide ? '0 : atot_reg[h];
    assign out_ftot   = hide ? '0 : ftot_reg[h];
    assign out_rtot   = hide ? '0 : rtot_reg[h];

`ifndef ASSERT_OFF
    a_no_take_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !q_pop) else $error("request taken during clear sweep");
    a_read_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_READ |=> state_reg == BK_OUT) else $error("missed result");
    a_ok_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_status != ST_OK |-> out_slot == '0 && !out_reused)
        else $error("slot on failed request");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_status))
        else $error("result dropped");
`endif

endmodule

[src/descriptor_free_list_allocator.sv]
// ---------------------------------------------------------------------------
// descriptor_free_list_allocator: slot allocator with free stack and high mark
// four heaps, each with a lifo free stack, a high-water mark and statistics
// ---------------------------------------------------------------------------
//  channel  | dir | transfer contents
//  s_axis   | in  | tdata[12:0] = operation, heap_type, free_index
//  m_axis   | out | tdata[142:0] = status .. reuse_total (see port)
//  apb      | in  | capacity_heap_0..3 at 0x0, 0x4, 0x8, 0xc
//
// each request passes the engine in order as take with memory read, update and
// result, and the engine takes no new request until its result is accepted.
// after reset a sweep clears the freed flags of all 4096 entries, and no
// request is taken until it is done. a stalled result blocks the engine while
// the two-entry input queue keeps taking transfers until it is full.
module descriptor_free_list_allocator
    import dfla_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[0], heap_type[2:1], free_index[12:3], zero fill
    input  logic [15:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], slot_index[12:3], was_reused[13], live_count[24:14],
    // free_stack_size[35:25], high_water[46:36], alloc_total[78:47],
    // free_total[110:79], reuse_total[142:111], zero fill
    output logic [143:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [CNT_W-1:0] cap_reg [HEAPS];
    logic             cfg_wr;
    logic [1:0]       cfg_sel;

    // apb register file, always ready
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[1:0] == 2'b00);
    assign cfg_sel = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HEAPS; i++) begin
                cap_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_CAP0: cap_reg[0] <= pwdata[CNT_W-1:0];
                REG_CAP1: cap_reg[1] <= pwdata[CNT_W-1:0];
                REG_CAP2: cap_reg[2] <= pwdata[CNT_W-1:0];
                REG_CAP3: cap_reg[3] <= pwdata[CNT_W-1:0];
                default:  ;
            endcase
        end
    end

    assign prdata = {21'd0, cap_reg[cfg_sel]};

    // front: input queue
    req_t in_req, q_req;
    logic q_valid, q_pop;

    assign in_req.op   = op_t'(s_axis_tdata[0]);
    assign in_req.heap = s_axis_tdata[2:1];
    assign in_req.idx  = s_axis_tdata[12:3];

    dfla_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req)
    );

    // back: allocator engine
    logic [2:0]       o_status;
    logic [IDX_W-1:0] o_slot;
    logic             o_reused;
    logic [CNT_W-1:0] o_live, o_stack, o_hw;
    logic [TOT_W-1:0] o_atot, o_ftot, o_rtot;

    dfla_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cap        (cap_reg),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_req      (q_req),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (o_status),
        .out_slot   (o_slot),
        .out_reused (o_reused),
        .out_live   (o_live),
        .out_stack  (o_stack),
        .out_hw     (o_hw),
        .out_atot   (o_atot),
        .out_ftot   (o_ftot),
        .out_rtot   (o_rtot)
    );

    assign m_axis_tdata = {1'b0, o_rtot, o_ftot, o_atot, o_hw, o_stack, o_live,
                           o_reused, o_slot, o_status};

endmodule
